// ----- hw/rtl/phc_pkg.sv -----
// ----------------------------------------------------------------------------
// Plane height classifier package
// Word types of the item and result channels, code constants and fixed sizes
// shared by the front, queue, back and top level.
// ----------------------------------------------------------------------------
package phc_pkg;

    // Fixed field sizes of the channel words
    localparam int COORD_IN_W   = 16;
    localparam int HEIGHT_W     = 16;
    localparam int MAX_HEIGHT_W = 15;

    // Quotient search covers 16 bits; the quotient is clipped at 2^15
    localparam int QUOT_W = 16;
    localparam logic [QUOT_W-1:0] QUOT_LIMIT = 16'h8000;

    // Region jobs waiting between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Item modes
    localparam logic MODE_CORNER = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Corner indices; CORNER_NONE writes nothing
    localparam logic [1:0] CORNER_0    = 2'd0;
    localparam logic [1:0] CORNER_1    = 2'd1;
    localparam logic [1:0] CORNER_2    = 2'd2;
    localparam logic [1:0] CORNER_NONE = 2'd3;

    // Level classes
    localparam logic [1:0] CLASS_LOW  = 2'd0;
    localparam logic [1:0] CLASS_MID  = 2'd1;
    localparam logic [1:0] CLASS_HIGH = 2'd2;

    // Status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_COLLINEAR = 1'b1;

    localparam logic [MAX_HEIGHT_W-1:0] MAX_HEIGHT_RESET = 15'd500;

    typedef struct packed {
        logic                         mode;
        logic [1:0]                   corner_index;
        logic signed [COORD_IN_W-1:0] x_coord;
        logic signed [COORD_IN_W-1:0] y_coord;
        logic signed [COORD_IN_W-1:0] z_coord;
        logic                         last_sample;
    } phc_item_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic [1:0]                 level_class;
        logic                       status;
    } phc_result_t;

endpackage

// ----- hw/rtl/phc_front.sv -----
// ----------------------------------------------------------------------------
// Plane height classifier front end
// Takes item words, keeps the corners and the plane, accumulates the signed
// plane distance of each sample and hands a finished region to the queue.
// ----------------------------------------------------------------------------
module phc_front
    import phc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int MAX_SAMPLES = 64,
    localparam int NW    = 2 * COORD_WIDTH + 4,
    localparam int OW    = NW + COORD_WIDTH + 2,
    localparam int TW    = OW + 1,
    localparam int CNTW  = $clog2(MAX_SAMPLES + 1),
    localparam int SW    = TW + CNTW,
    localparam int JOB_W = SW + CNTW + 3 * NW
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  phc_item_t        item,
    output logic             job_valid,
    input  logic             job_ready,
    output logic [JOB_W-1:0] job_data
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int MW = 2 * DW;
    localparam int PW = NW + CW;

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_DIFF  = 7'b0000010,
        F_CROSS = 7'b0000100,
        F_NORM  = 7'b0001000,
        F_OFFM  = 7'b0010000,
        F_OFFS  = 7'b0100000,
        F_ACC   = 7'b1000000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic signed [CW-1:0] corner_reg [9];
    logic signed [DW-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [MW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [NW-1:0] na_reg, nb_reg, nc_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [OW-1:0] offset_reg;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic                 last_reg;

    logic signed [CW-1:0] cx, cy, cz;
    logic signed [TW-1:0] term;
    logic                 take;
    logic                 done;

    // Coordinates use the low bits, taken as signed
    assign cx = $signed(item.x_coord[CW-1:0]);
    assign cy = $signed(item.y_coord[CW-1:0]);
    assign cz = $signed(item.z_coord[CW-1:0]);

    assign item_ready = (state_reg == F_IDLE);
    assign take       = item_valid && item_ready;

    // Distance term of the held sample and the updated region totals
    assign term = TW'(p0_reg) + TW'(p1_reg) + TW'(p2_reg) + TW'(offset_reg);

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cnt_reg < CNTW'(MAX_SAMPLES))
        begin
            sum_next = sum_reg + SW'(term);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign job_valid = (state_reg == F_ACC) && last_reg;
    assign job_data  = {sum_next, cnt_next, na_reg, nb_reg, nc_reg};
    assign done      = !last_reg || job_ready;

    // Sequence corner loads and sample accumulation
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    if (item.mode == MODE_SAMPLE)
                        state_next = F_ACC;
                    else if (item.corner_index != CORNER_NONE)
                        state_next = F_DIFF;
                end
            end
            F_DIFF:  state_next = F_CROSS;
            F_CROSS: state_next = F_NORM;
            F_NORM:  state_next = F_OFFM;
            F_OFFM:  state_next = F_OFFS;
            F_OFFS:  state_next = F_IDLE;
            F_ACC:
            begin
                if (done)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Control and plane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            na_reg     <= '0;
            nb_reg     <= '0;
            nc_reg     <= '0;
            offset_reg <= '0;
            for (int i = 0; i < 9; i++)
            begin
                corner_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Write the addressed corner
            if (take && item.mode == MODE_CORNER)
            begin
                case (item.corner_index)
                    CORNER_0:
                    begin
                        corner_reg[0] <= cx;
                        corner_reg[1] <= cy;
                        corner_reg[2] <= cz;
                    end
                    CORNER_1:
                    begin
                        corner_reg[3] <= cx;
                        corner_reg[4] <= cy;
                        corner_reg[5] <= cz;
                    end
                    CORNER_2:
                    begin
                        corner_reg[6] <= cx;
                        corner_reg[7] <= cy;
                        corner_reg[8] <= cz;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Form the normal from the cross products
            if (state_reg == F_NORM)
            begin
                na_reg <= NW'(m0_reg) - NW'(m1_reg);
                nb_reg <= NW'(m2_reg) - NW'(m3_reg);
                nc_reg <= NW'(m4_reg) - NW'(m5_reg);
            end

            if (state_reg == F_OFFS)
                offset_reg <= -(OW'(p0_reg) + OW'(p1_reg) + OW'(p2_reg));

            // Advance the region totals; clear them once the region is handed off
            if (state_reg == F_ACC && done)
            begin
                if (last_reg)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == F_DIFF)
        begin
            ux_reg <= DW'(corner_reg[3]) - DW'(corner_reg[0]);
            uy_reg <= DW'(corner_reg[4]) - DW'(corner_reg[1]);
            uz_reg <= DW'(corner_reg[5]) - DW'(corner_reg[2]);
            vx_reg <= DW'(corner_reg[6]) - DW'(corner_reg[0]);
            vy_reg <= DW'(corner_reg[7]) - DW'(corner_reg[1]);
            vz_reg <= DW'(corner_reg[8]) - DW'(corner_reg[2]);
        end

        if (state_reg == F_CROSS)
        begin
            m0_reg <= uy_reg * vz_reg;
            m1_reg <= uz_reg * vy_reg;
            m2_reg <= uz_reg * vx_reg;
            m3_reg <= ux_reg * vz_reg;
            m4_reg <= ux_reg * vy_reg;
            m5_reg <= uy_reg * vx_reg;
        end

        // Products feed either the offset or the sample distance
        if (state_reg == F_OFFM)
        begin
            p0_reg <= na_reg * corner_reg[0];
            p1_reg <= nb_reg * corner_reg[1];
            p2_reg <= nc_reg * corner_reg[2];
        end
        else if (take && item.mode == MODE_SAMPLE)
        begin
            p0_reg   <= na_reg * cx;
            p1_reg   <= nb_reg * cy;
            p2_reg   <= nc_reg * cz;
            last_reg <= item.last_sample;
        end
    end

endmodule

// ----- hw/rtl/phc_queue.sv -----
// ----------------------------------------------------------------------------
// Plane height classifier region queue
// Small first-in first-out store of finished region jobs between the front
// and the back end.
// ----------------------------------------------------------------------------
module phc_queue
    import phc_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push, pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Advance pointers; depth is a power of two so they wrap by themselves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // Hold the words
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/phc_back.sv -----
// ----------------------------------------------------------------------------
// Plane height classifier back end
// Turns a region job into the mean plane distance: squares and products on a
// shift-add multiplier, then a bit-by-bit quotient search over squared values,
// and holds the result word in an output register.
// ----------------------------------------------------------------------------
module phc_back
    import phc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int MAX_SAMPLES = 64,
    localparam int NW    = 2 * COORD_WIDTH + 4,
    localparam int OW    = NW + COORD_WIDTH + 2,
    localparam int TW    = OW + 1,
    localparam int CNTW  = $clog2(MAX_SAMPLES + 1),
    localparam int SW    = TW + CNTW,
    localparam int JOB_W = SW + CNTW + 3 * NW
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  logic [JOB_W-1:0]        job_data,
    input  logic [MAX_HEIGHT_W-1:0] max_height,
    output logic                    result_valid,
    input  logic                    result_ready,
    output phc_result_t             result
);

    localparam int NNW   = 2 * NW + 2;
    localparam int KW    = NNW + 2 * CNTW;
    localparam int LW    = (KW + 2 * QUOT_W > 2 * SW) ? KW + 2 * QUOT_W : 2 * SW;
    localparam int QKW   = KW + QUOT_W;
    localparam int BIT_W = $clog2(QUOT_W);
    localparam int HQ_W  = QUOT_W + 1;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_SRCH = 4'b0100,
        B_OUT  = 4'b1000
    } back_state_t;

    typedef enum logic [2:0] {
        OP_SQ_A,
        OP_SQ_B,
        OP_SQ_C,
        OP_K,
        OP_S2
    } mul_op_t;

    back_state_t state_reg;
    mul_op_t     op_reg;

    // Job fields
    logic signed [SW-1:0] j_sum;
    logic [CNTW-1:0]      j_cnt;
    logic signed [NW-1:0] j_a, j_b, j_c;
    logic [NW-1:0]        a_mag, b_mag, c_mag;
    logic                 j_zero;

    logic [NW-1:0]     bmag_reg, cmag_reg;
    logic [SW-1:0]     smag_reg;
    logic              sneg_reg;
    logic              zero_reg;
    logic [2*CNTW-1:0] n2_reg;

    // Multiplier and search registers
    logic [LW-1:0]      mx_reg, acc_reg;
    logic [SW-1:0]      my_reg;
    logic [KW-1:0]      k_reg;
    logic [LW-1:0]      s2_reg, t_reg;
    logic [QKW-1:0]     qk_reg;
    logic [QUOT_W-1:0]  q_reg;
    logic [BIT_W-1:0]   bit_reg;

    logic               res_valid_reg;
    phc_result_t        res_reg;

    logic [LW+1:0]      cand;
    logic               fits;
    logic               load_out;
    logic [QUOT_W-1:0]  q_clip;
    logic signed [HQ_W-1:0] hq;
    phc_result_t        res_next;

    assign {j_sum, j_cnt, j_a, j_b, j_c} = job_data;
    assign a_mag  = j_a[NW-1] ? NW'(-j_a) : NW'(j_a);
    assign b_mag  = j_b[NW-1] ? NW'(-j_b) : NW'(j_b);
    assign c_mag  = j_c[NW-1] ? NW'(-j_c) : NW'(j_c);
    assign j_zero = (j_a == '0) && (j_b == '0) && (j_c == '0);

    assign job_ready = (state_reg == B_IDLE);

    // Trial quotient with the current bit set, in squared form
    assign cand = (LW + 2)'(t_reg)
                + ((LW + 2)'(qk_reg) << ({1'b0, bit_reg} + 1'b1))
                + ((LW + 2)'(k_reg) << {bit_reg, 1'b0});
    assign fits = (cand <= (LW + 2)'(s2_reg));

    // Build the result word
    assign q_clip = (q_reg > QUOT_LIMIT) ? QUOT_LIMIT : q_reg;
    assign hq     = sneg_reg ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});

    always_comb
    begin
        res_next.height = (hq > $signed(HQ_W'(2 ** (HEIGHT_W - 1) - 1)))
                        ? HEIGHT_W'(2 ** (HEIGHT_W - 1) - 1) : hq[HEIGHT_W-1:0];
        if (hq > $signed({2'b00, max_height}))
            res_next.level_class = CLASS_HIGH;
        else if (hq < $signed({3'b000, max_height[MAX_HEIGHT_W-1:1]}))
            res_next.level_class = CLASS_LOW;
        else
            res_next.level_class = CLASS_MID;
        res_next.status = zero_reg ? STATUS_COLLINEAR : STATUS_OK;
    end

    assign load_out     = (state_reg == B_OUT) && (!res_valid_reg || result_ready);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            op_reg        <= OP_SQ_A;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        op_reg <= OP_SQ_A;
                        if (j_zero || j_cnt == '0)
                            state_reg <= B_OUT;
                        else
                            state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    if (my_reg == '0)
                    begin
                        case (op_reg)
                            OP_SQ_A: op_reg <= OP_SQ_B;
                            OP_SQ_B: op_reg <= OP_SQ_C;
                            OP_SQ_C: op_reg <= OP_K;
                            OP_K:    op_reg <= OP_S2;
                            default: state_reg <= B_SRCH;
                        endcase
                    end
                end
                B_SRCH:
                begin
                    if (bit_reg == '0)
                        state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (load_out)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase

            // Hold the result until taken
            if (load_out)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    sneg_reg <= j_sum[SW-1];
                    smag_reg <= j_sum[SW-1] ? SW'(-j_sum) : SW'(j_sum);
                    zero_reg <= j_zero;
                    n2_reg   <= j_cnt * j_cnt;
                    bmag_reg <= b_mag;
                    cmag_reg <= c_mag;
                    mx_reg   <= LW'(a_mag);
                    my_reg   <= SW'(a_mag);
                    acc_reg  <= '0;
                    q_reg    <= '0;
                end
            end
            B_MUL:
            begin
                if (my_reg != '0)
                begin
                    // One shift-add step
                    if (my_reg[0])
                        acc_reg <= acc_reg + mx_reg;
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg >> 1;
                end
                else
                begin
                    case (op_reg)
                        OP_SQ_A:
                        begin
                            mx_reg <= LW'(bmag_reg);
                            my_reg <= SW'(bmag_reg);
                        end
                        OP_SQ_B:
                        begin
                            mx_reg <= LW'(cmag_reg);
                            my_reg <= SW'(cmag_reg);
                        end
                        OP_SQ_C:
                        begin
                            mx_reg  <= acc_reg;
                            my_reg  <= SW'(n2_reg);
                            acc_reg <= '0;
                        end
                        OP_K:
                        begin
                            k_reg   <= acc_reg[KW-1:0];
                            mx_reg  <= LW'(smag_reg);
                            my_reg  <= smag_reg;
                            acc_reg <= '0;
                        end
                        default:
                        begin
                            s2_reg  <= acc_reg;
                            t_reg   <= '0;
                            qk_reg  <= '0;
                            q_reg   <= '0;
                            bit_reg <= BIT_W'(QUOT_W - 1);
                        end
                    endcase
                end
            end
            B_SRCH:
            begin
                if (fits)
                begin
                    t_reg          <= cand[LW-1:0];
                    qk_reg         <= qk_reg + (QKW'(k_reg) << bit_reg);
                    q_reg[bit_reg] <= 1'b1;
                end
                bit_reg <= bit_reg - 1'b1;
            end
            default:
            begin
            end
        endcase

        if (load_out)
            res_reg <= res_next;
    end

endmodule

// ----- hw/rtl/plane_height_classifier.sv -----
// ----------------------------------------------------------------------------
// Plane height classifier
// Loads three plane corners, streams region samples and reports the signed
// mean distance of each region to the plane with a level class.
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------
//   item     | item_valid/ready     | phc_item_t: corner load or sample
//   result   | result_valid/ready   | phc_result_t: height, class, status
//   cfg      | cfg_valid/ready      | max_height, always ready
//
// In the front, a sample is multiplied and then accumulated; a corner load
// rebuilds the plane through difference, cross-product, normal, offset-product
// and offset steps. The back end works each of its five shift-add products
// bit by bit over the multiplier operand, then takes 16 quotient steps; a
// four-entry queue lets that overlap later regions. Reset clears control
// state and sets max_height to 500; a full queue or held result stalls.
// ----------------------------------------------------------------------------
module plane_height_classifier
    import phc_pkg::*;
#(
    parameter int MAX_SAMPLES = 64,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  phc_item_t               item,
    output logic                    result_valid,
    input  logic                    result_ready,
    output phc_result_t             result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [MAX_HEIGHT_W-1:0] cfg_data
);

    localparam int NW    = 2 * COORD_WIDTH + 4;
    localparam int OW    = NW + COORD_WIDTH + 2;
    localparam int TW    = OW + 1;
    localparam int CNTW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW    = TW + CNTW;
    localparam int JOB_W = SW + CNTW + 3 * NW;

    logic [MAX_HEIGHT_W-1:0] max_height_reg;
    logic                    fj_valid, fj_ready, bj_valid, bj_ready;
    logic [JOB_W-1:0]        fj_data, bj_data;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_height_reg <= MAX_HEIGHT_RESET;
        else if (cfg_valid && cfg_ready)
            max_height_reg <= cfg_data;
    end

    phc_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_valid  (fj_valid),
        .job_ready  (fj_ready),
        .job_data   (fj_data)
    );

    phc_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_data  (fj_data),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_data   (bj_data)
    );

    phc_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (bj_valid),
        .job_ready    (bj_ready),
        .job_data     (bj_data),
        .max_height   (max_height_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- verif/plane_height_checker.sv -----
// ----------------------------------------------------------------------------
// Plane height checker
// Watches the item, result and cfg channels of the plane height classifier,
// keeps its own copy of the plane, the region sum and max_height, works out
// the report due for each region and compares it with each result word.
// ----------------------------------------------------------------------------
module plane_height_checker
    import phc_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  logic                    item_ready,
    input  phc_item_t               item,
    input  logic                    result_valid,
    input  logic                    result_ready,
    input  phc_result_t             result,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [MAX_HEIGHT_W-1:0] cfg_data,
    output int                      fail_count,
    output int                      pending
);

    longint                  corner_pt [9];
    longint                  normal_v [3];
    longint                  offset_d;
    longint                  region_sum;
    int                      region_cnt;
    logic [MAX_HEIGHT_W-1:0] max_h;
    phc_result_t             reports_due [$];

    assign pending = reports_due.size();

    // Largest q up to 32768 with q^2 * n^2 * |normal|^2 <= sum^2
    function automatic longint mean_quotient(longint unsigned smag, longint unsigned n,
                                             logic [255:0] nn);
        logic [255:0]    s2;
        logic [255:0]    k;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        s2 = {192'd0, smag} * {192'd0, smag};
        k  = {192'd0, n} * {192'd0, n} * nn;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if ({192'd0, mid * mid} * k <= s2)
                lo = mid;
            else
                hi = mid - 1;
        end
        return longint'(lo);
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? 64'd0 - longint'(v) : v;
    endfunction

    // Rebuild normal and offset from the three stored corners
    function automatic void rebuild_plane();
        longint ux, uy, uz, vx, vy, vz;
        ux = corner_pt[3] - corner_pt[0];
        uy = corner_pt[4] - corner_pt[1];
        uz = corner_pt[5] - corner_pt[2];
        vx = corner_pt[6] - corner_pt[0];
        vy = corner_pt[7] - corner_pt[1];
        vz = corner_pt[8] - corner_pt[2];
        normal_v[0] = uy * vz - uz * vy;
        normal_v[1] = uz * vx - ux * vz;
        normal_v[2] = ux * vy - uy * vx;
        offset_d = -(normal_v[0] * corner_pt[0] + normal_v[1] * corner_pt[1]
                     + normal_v[2] * corner_pt[2]);
    endfunction

    // Close a region: mean height, class and status
    function automatic phc_result_t classify_region();
        phc_result_t  r;
        logic [255:0] nn;
        longint       q;
        longint       hq;
        logic         flat;
        nn = 0;
        for (int i = 0; i < 3; i++)
            nn += {192'd0, magnitude(normal_v[i])} * {192'd0, magnitude(normal_v[i])};
        flat = (normal_v[0] == 0) && (normal_v[1] == 0) && (normal_v[2] == 0);
        q = 0;
        if (!flat && region_cnt != 0)
            q = mean_quotient(magnitude(region_sum), region_cnt, nn);
        hq = (region_sum < 0) ? -q : q;
        if (flat)
            hq = 0;
        r.height = (hq > 32767) ? 16'sh7fff : hq[15:0];
        if (hq > longint'(max_h))
            r.level_class = CLASS_HIGH;
        else if (hq < longint'(max_h / 2))
            r.level_class = CLASS_LOW;
        else
            r.level_class = CLASS_MID;
        r.status = flat ? STATUS_COLLINEAR : STATUS_OK;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        phc_result_t got;
        phc_result_t want;
        if (!rst_n)
        begin
            foreach (corner_pt[i])
                corner_pt[i] = 0;
            foreach (normal_v[i])
                normal_v[i] = 0;
            offset_d   = 0;
            region_sum = 0;
            region_cnt = 0;
            max_h      = MAX_HEIGHT_RESET;
            fail_count = 0;
            reports_due.delete();
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
                max_h = cfg_data;

            // Check the result word against the oldest report due
            if (result_valid && result_ready)
            begin
                got = result;
                if (reports_due.size() == 0)
                begin
                    $display("%0t: unexpected result word, actual h=%0d cls=%0d st=%0d",
                             $time, got.height, got.level_class, got.status);
                    fail_count++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (got.height !== want.height)
                    begin
                        $display("%0t: height mismatch, expected %0d actual %0d",
                                 $time, want.height, got.height);
                        fail_count++;
                    end
                    if (got.level_class !== want.level_class)
                    begin
                        $display("%0t: level_class mismatch, expected %0d actual %0d",
                                 $time, want.level_class, got.level_class);
                        fail_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                end
            end

            // Advance the model on each accepted item word
            if (item_valid && item_ready)
            begin
                if (item.mode == MODE_CORNER)
                begin
                    if (item.corner_index != CORNER_NONE)
                    begin
                        corner_pt[item.corner_index * 3]     = item.x_coord;
                        corner_pt[item.corner_index * 3 + 1] = item.y_coord;
                        corner_pt[item.corner_index * 3 + 2] = item.z_coord;
                        rebuild_plane();
                    end
                end
                else
                begin
                    if (region_cnt < MAX_SAMPLES)
                    begin
                        region_sum += normal_v[0] * longint'(item.x_coord)
                                    + normal_v[1] * longint'(item.y_coord)
                                    + normal_v[2] * longint'(item.z_coord) + offset_d;
                        region_cnt++;
                    end
                    if (item.last_sample)
                    begin
                        reports_due.insert(reports_due.size(), classify_region());
                        region_sum = 0;
                        region_cnt = 0;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/plane_height_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// Plane height classifier testbench
// Drives corner loads and region samples with random gaps and stalls, writes
// max_height between phases and lets the checker judge every result word.
// ----------------------------------------------------------------------------
module plane_height_classifier_tb;
    import phc_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 300;
    localparam int ITEM_W      = $bits(phc_item_t);

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_ready;
    phc_item_t               item;
    logic                    result_valid;
    logic                    result_ready;
    phc_result_t             result;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [MAX_HEIGHT_W-1:0] cfg_data;
    int                      fail_count;
    int                      pending;

    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold;
    int quiet_cycles;

    plane_height_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    plane_height_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off when asked
    initial
    begin
        int hold_left;
        bit hold_used;
        result_ready = 1'b0;
        hold_left = 0;
        hold_used = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_used)
            begin
                hold_used = 1;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: count cycles without any accepted word
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one item word; starts and ends at a falling edge
    task automatic send_word(input phc_item_t w);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    task automatic send_point(input logic mode, input logic [1:0] idx,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z, input logic last);
        phc_item_t w;
        w.mode = mode;
        w.corner_index = idx;
        w.x_coord = x;
        w.y_coord = y;
        w.z_coord = z;
        w.last_sample = last;
        send_word(w);
    endtask

    // Write max_height once nothing is outstanding
    task automatic write_max_height(input logic [MAX_HEIGHT_W-1:0] v);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord(input bit wide);
        return wide ? 16'($urandom) : 16'($urandom_range(400) - 200);
    endfunction

    // Sometimes a random plane, then a region; sometimes noise instead, or an overlong region
    task automatic random_region(inout int sent);
        int                n;
        bit                wide;
        logic [ITEM_W-1:0] raw;
        wide = ($urandom_range(3) == 0);
        if ($urandom_range(9) == 0)
        begin
            if ($urandom_range(1) != 0)
                raw = ITEM_W'({$urandom, $urandom});
            else
                raw = ITEM_W'($urandom);
            send_word(phc_item_t'(raw));
            sent++;
            return;
        end
        if ($urandom_range(2) != 0)
            for (int c = 0; c < 3; c++)
            begin
                if ($urandom_range(4) == 0 || c < 3)
                begin
                    send_point(MODE_CORNER, 2'(c), rand_coord(wide), rand_coord(wide),
                               rand_coord(wide), 1'($urandom));
                    sent++;
                end
            end
        n = ($urandom_range(29) == 0) ? $urandom_range(65, 72) : $urandom_range(1, 6);
        for (int s = 0; s < n; s++)
        begin
            send_point(MODE_SAMPLE, 2'($urandom), rand_coord(wide), rand_coord(wide),
                       rand_coord(wide), s == n - 1);
            sent++;
        end
    endtask

    initial
    begin
        int sent;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        tx_idle_pct = 37;
        rx_idle_pct = 52;
        long_hold   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: no plane yet, so the region is collinear
        send_point(MODE_SAMPLE, CORNER_0, 16'sd5, 16'sd5, 16'sd5, 1'b1);
        // Plane z = 0 from extreme corners, corner load with last set
        send_point(MODE_CORNER, CORNER_0, 16'sh8000, 16'sh8000, 16'sd0, 1'b1);
        send_point(MODE_CORNER, CORNER_1, 16'sh7fff, 16'sh8000, 16'sd0, 1'b0);
        send_point(MODE_CORNER, CORNER_2, 16'sh8000, 16'sh7fff, 16'sd0, 1'b0);
        // Index three is ignored
        send_point(MODE_CORNER, CORNER_NONE, 16'sd1, 16'sd2, 16'sd3, 1'b0);
        send_point(MODE_SAMPLE, CORNER_0, 16'sd0, 16'sd0, 16'sh7fff, 1'b1);
        send_point(MODE_SAMPLE, CORNER_0, 16'sd0, 16'sd0, 16'sh8000, 1'b1);
        send_point(MODE_SAMPLE, CORNER_0, 16'sh7fff, 16'sh8000, 16'sd300, 1'b0);
        send_point(MODE_SAMPLE, CORNER_0, 16'sd0, 16'sd0, 16'sd200, 1'b1);
        send_point(MODE_SAMPLE, CORNER_0, 16'sd0, 16'sd0, -16'sd400, 1'b1);
        send_point(MODE_SAMPLE, CORNER_0, 16'sd0, 16'sd0, 16'sd600, 1'b1);
        // Collinear corners
        send_point(MODE_CORNER, CORNER_1, 16'sd1, 16'sd1, 16'sd1, 1'b0);
        send_point(MODE_CORNER, CORNER_2, 16'sd2, 16'sd2, 16'sd2, 1'b0);
        send_point(MODE_CORNER, CORNER_0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_point(MODE_SAMPLE, CORNER_0, 16'sd9, 16'sd0, 16'sd0, 1'b1);
        // Tilted plane, region past the sample limit
        send_point(MODE_CORNER, CORNER_1, 16'sd100, 16'sd0, 16'sd10, 1'b0);
        send_point(MODE_CORNER, CORNER_2, 16'sd0, 16'sd100, -16'sd20, 1'b0);
        for (int s = 0; s < 70; s++)
            send_point(MODE_SAMPLE, CORNER_0, 16'(s), 16'(-s), 16'(s * 9), s == 69);

        // Phase one: sender idles 37%, receiver 52%
        sent = 0;
        write_max_height(15'd0);
        while (sent < 400)
            random_region(sent);

        // Phase two: roles swapped
        tx_idle_pct = 52;
        rx_idle_pct = 37;
        write_max_height(15'h7fff);
        sent = 0;
        while (sent < 400)
            random_region(sent);

        // Phase three: no idling; one long hold-off to fill the block
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_max_height(15'($urandom_range(20, 3000)));
        long_hold = 1;
        sent = 0;
        while (sent < 400)
            random_region(sent);
        item_valid <= 1'b0;

        // Drain
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
